>>> rtl/core/spmd_pkg.sv
// package: shared types, constants and codes of the sorted pair merge block
`timescale 1ns / 1ps
`default_nettype none
package spmd_pkg;

	localparam int ListDepth  = 32;
	localparam int CntW       = $clog2(ListDepth + 1);
	localparam int AddrW      = (ListDepth > 1) ? $clog2(ListDepth) : 1;
	localparam int QueueDepth = 2;
	localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QCntW      = $clog2(QueueDepth + 1);

	localparam logic [63:0] OrderFlip = 64'h8000_0000_8000_0000;

	// input command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_PAIR   = 2'd2;
	localparam logic [1:0] CMD_END    = 2'd3;

	// merge_mode register values
	localparam logic MODE_MERGE = 1'b0;
	localparam logic MODE_DIFF  = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_PAIR,
		OP_END
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EXEC
	} state_t;

	// one classified item: row in the high half, col in the low half
	typedef struct packed {
		op_t         op;
		logic [63:0] pair;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_push_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	typedef struct packed {
		logic [CntW-1:0] count;
		logic [CntW-1:0] cursor;
	} back_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/spmd_ifs.sv
// interfaces: input item channel and result item channel
`timescale 1ns / 1ps
`default_nettype none
interface spmd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [31:0] elem_row;
	logic signed [31:0] elem_col;

	modport source (output valid, output cmd, output elem_row, output elem_col, input ready);
	modport sink   (input valid, input cmd, input elem_row, input elem_col, output ready);
endinterface

interface spmd_out_if;
	logic               valid;
	logic               ready;
	logic               has_element;
	logic signed [31:0] out_row;
	logic signed [31:0] out_col;
	logic               status;
	logic               last;

	modport source (output valid, output has_element, output out_row, output out_col,
		output status, output last, input ready);
	modport sink   (input valid, input has_element, input out_row, input out_col,
		input status, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spmd_front.sv
// front: accepts input items and classifies them into operations
`timescale 1ns / 1ps
`default_nettype none
module spmd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	spmd_in_if.sink                 in_ch,
	output spmd_pkg::q_push_t       push,
	input  wire logic               q_ready
);

	logic              valid_s1;
	spmd_pkg::q_item_t item_s1;
	spmd_pkg::op_t     op_dec;
	logic              accept;

	assign in_ch.ready = !valid_s1 || q_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		case (in_ch.cmd)
			spmd_pkg::CMD_CLEAR:  op_dec = spmd_pkg::OP_CLEAR;
			spmd_pkg::CMD_APPEND: op_dec = spmd_pkg::OP_APPEND;
			spmd_pkg::CMD_PAIR:   op_dec = spmd_pkg::OP_PAIR;
			spmd_pkg::CMD_END:    op_dec = spmd_pkg::OP_END;
			default:              op_dec = spmd_pkg::OP_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !q_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op   <= op_dec;
			item_s1.pair <= {in_ch.elem_row, in_ch.elem_col};
		end
	end

	assign push.valid = valid_s1;
	assign push.item  = item_s1;

endmodule
`default_nettype wire

>>> rtl/core/spmd_queue.sv
// queue: short fifo of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none
module spmd_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire spmd_pkg::q_push_t  push,
	output logic                    q_ready,
	output spmd_pkg::q_head_t       head,
	input  wire logic               pop
);

	spmd_pkg::q_item_t              entry_q [spmd_pkg::QueueDepth];
	logic [spmd_pkg::QPtrW-1:0]     wr_ptr_q;
	logic [spmd_pkg::QPtrW-1:0]     rd_ptr_q;
	logic [spmd_pkg::QCntW-1:0]     fill_q;
	logic                           do_push;
	logic                           do_pop;

	assign q_ready = (fill_q != spmd_pkg::QCntW'(spmd_pkg::QueueDepth));
	assign do_push = push.valid && q_ready;
	assign do_pop  = pop && (fill_q != '0);

	assign head.valid = (fill_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == spmd_pkg::QPtrW'(spmd_pkg::QueueDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == spmd_pkg::QPtrW'(spmd_pkg::QueueDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.item;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/spmd_back.sv
// back: stored list memory, cursor and result sequencing
`timescale 1ns / 1ps
`default_nettype none
module spmd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               merge_mode_we,
	input  wire logic               merge_mode_wdata,
	input  wire spmd_pkg::q_head_t  head,
	output logic                    pop,
	spmd_out_if.source              out_ch,
	output spmd_pkg::back_stat_t    stat
);

	spmd_pkg::state_t               state_q, state_nxt;
	spmd_pkg::q_item_t              cur_q;
	logic [63:0]                    mem_q [spmd_pkg::ListDepth];
	logic [63:0]                    rd_q;
	logic [spmd_pkg::CntW-1:0]      count_q;
	logic [spmd_pkg::CntW-1:0]      cursor_q;
	logic [spmd_pkg::CntW-1:0]      cursor_inc;
	logic                           merge_mode_q;

	logic                           slot_free;
	logic                           has_more;
	logic                           rd_less;
	logic                           is_full;

	// decisions made in the execute state
	logic                           emit;
	logic                           emit_has;
	logic [63:0]                    emit_pair;
	logic                           emit_status;
	logic                           emit_last;
	logic                           cur_advance;
	logic                           cur_zero;
	logic                           cnt_zero;
	logic                           mem_wr;

	logic                           out_valid_q;
	logic                           out_has_q;
	logic [63:0]                    out_pair_q;
	logic                           out_status_q;
	logic                           out_last_q;

	assign slot_free  = !out_valid_q || out_ch.ready;
	assign has_more   = (cursor_q < count_q);
	assign rd_less    = ((rd_q ^ spmd_pkg::OrderFlip) < (cur_q.pair ^ spmd_pkg::OrderFlip));
	assign is_full    = (count_q == spmd_pkg::CntW'(spmd_pkg::ListDepth));
	assign cursor_inc = cursor_q + 1'b1;

	always_comb begin
		emit        = 1'b0;
		emit_has    = 1'b0;
		emit_pair   = cur_q.pair;
		emit_status = 1'b0;
		emit_last   = 1'b1;
		cur_advance = 1'b0;
		cur_zero    = 1'b0;
		cnt_zero    = 1'b0;
		mem_wr      = 1'b0;
		if (state_q == spmd_pkg::S_EXEC && slot_free) begin
			emit = 1'b1;
			case (cur_q.op)
				spmd_pkg::OP_CLEAR: begin
					cnt_zero = 1'b1;
					cur_zero = 1'b1;
				end
				spmd_pkg::OP_APPEND: begin
					if (is_full) begin
						emit_status = 1'b1;
					end else begin
						mem_wr = 1'b1;
					end
				end
				spmd_pkg::OP_PAIR: begin
					if (merge_mode_q == spmd_pkg::MODE_MERGE) begin
						emit_has = 1'b1;
						if (has_more && rd_less) begin
							emit_pair   = rd_q;
							emit_last   = 1'b0;
							cur_advance = 1'b1;
						end
					end else begin
						if (has_more && (rd_q == cur_q.pair)) begin
							cur_advance = 1'b1;
						end else begin
							emit_has = 1'b1;
						end
					end
				end
				spmd_pkg::OP_END: begin
					if (merge_mode_q == spmd_pkg::MODE_MERGE && has_more) begin
						emit_has  = 1'b1;
						emit_pair = rd_q;
						emit_last = (cursor_inc == count_q);
						if (cursor_inc == count_q) begin
							cur_zero = 1'b1;
						end else begin
							cur_advance = 1'b1;
						end
					end else begin
						cur_zero = 1'b1;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			spmd_pkg::S_IDLE: begin
				if (head.valid) begin
					state_nxt = spmd_pkg::S_READ;
				end
			end
			spmd_pkg::S_READ: begin
				state_nxt = spmd_pkg::S_EXEC;
			end
			spmd_pkg::S_EXEC: begin
				if (slot_free) begin
					if (!emit_last) begin
						state_nxt = spmd_pkg::S_READ;
					end else if (head.valid) begin
						state_nxt = spmd_pkg::S_READ;
					end else begin
						state_nxt = spmd_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = spmd_pkg::S_IDLE;
			end
		endcase
	end

	// take the next item when idle or when the current one has sent its last result
	always_comb begin
		pop = 1'b0;
		case (state_q)
			spmd_pkg::S_IDLE: begin
				pop = head.valid;
			end
			spmd_pkg::S_EXEC: begin
				pop = slot_free && emit_last && head.valid;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= spmd_pkg::S_IDLE;
			count_q      <= '0;
			cursor_q     <= '0;
			merge_mode_q <= spmd_pkg::MODE_MERGE;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (merge_mode_we) begin
				merge_mode_q <= merge_mode_wdata;
			end
			if (cnt_zero) begin
				count_q <= '0;
			end else if (mem_wr) begin
				count_q <= count_q + 1'b1;
			end
			if (cur_zero) begin
				cursor_q <= '0;
			end else if (cur_advance) begin
				cursor_q <= cursor_inc;
			end
			out_valid_q <= emit || (out_valid_q && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.item;
		end
		if (emit) begin
			out_has_q    <= emit_has;
			out_pair_q   <= emit_has ? emit_pair : 64'd0;
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
		end
	end

	// stored list memory, registered read at the cursor
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[count_q[spmd_pkg::AddrW-1:0]] <= cur_q.pair;
		end
		rd_q <= mem_q[cursor_q[spmd_pkg::AddrW-1:0]];
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.has_element = out_has_q;
	assign out_ch.out_row     = out_pair_q[63:32];
	assign out_ch.out_col     = out_pair_q[31:0];
	assign out_ch.status      = out_status_q;
	assign out_ch.last        = out_last_q;

	assign stat.count  = count_q;
	assign stat.cursor = cursor_q;

endmodule
`default_nettype wire

>>> rtl/core/sorted_pair_merge_difference.sv
// top level: sorted pair merge and difference block
//
//   channel       dir   handshake       payload
//   in_ch         in    valid / ready   cmd, elem_row, elem_col
//   out_ch        out   valid / ready   has_element, out_row, out_col, status, last
//   merge_mode    in    we only         merge_mode_wdata (1 bit)
//
// in the back part each item passes the read state, which reads the stored list at the
//   cursor (registered memory read), then the execute state, which decides and loads
//   the result register; in merge mode each stored pair released passes both again
// the front register and a 2-entry queue keep taking items while the back part works
//   or the result waits
// arst_n clears stored count, cursor, mode and all valid flags; list contents stay
// a stall on out_ch holds the back part; the front fills the queue, then drops ready
`timescale 1ns / 1ps
`default_nettype none
module sorted_pair_merge_difference (
	input  wire logic   clk,
	input  wire logic   arst_n,
	spmd_in_if.sink     in_ch,
	spmd_out_if.source  out_ch,
	input  wire logic   merge_mode_we,
	input  wire logic   merge_mode_wdata
);

	// front to queue
	spmd_pkg::q_push_t    push;
	logic                 q_ready;
	// queue to back
	spmd_pkg::q_head_t    head;
	logic                 pop;
	// back status for checks
	spmd_pkg::back_stat_t stat;

	// accept and classify items
	spmd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.push    (push),
		.q_ready (q_ready)
	);

	// decouples acceptance from execution
	spmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.q_ready (q_ready),
		.head    (head),
		.pop     (pop)
	);

	// list storage, cursor walk and result register
	spmd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.merge_mode_we    (merge_mode_we),
		.merge_mode_wdata (merge_mode_wdata),
		.head             (head),
		.pop              (pop),
		.out_ch           (out_ch),
		.stat             (stat)
	);

	// cursor never passes the stored count
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cursor <= stat.count)
		else $error("cursor beyond stored count");

	// stored count never exceeds the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= spmd_pkg::CntW'(spmd_pkg::ListDepth))
		else $error("stored count beyond depth");

	// a refused append is a lone, final, empty result
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status) |-> (!out_ch.has_element && out_ch.last))
		else $error("full status on a non-final or non-empty result");

	// an empty result carries zero coordinates
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.has_element) |-> (out_ch.out_row == 0 && out_ch.out_col == 0))
		else $error("empty result with nonzero coordinates");

endmodule
`default_nettype wire

>>> dv/sorted_pair_merge_difference_tb.sv
// testbench: random and directed checking of the sorted pair merge and difference block
`timescale 1ns / 1ps
module sorted_pair_merge_difference_tb;

	localparam logic [31:0] COORD_MIN = 32'h8000_0000;
	localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] COORD_NEG1 = 32'hffff_ffff;

	// one input item as it waits in the send queue: row in the high half, col in the low
	typedef struct {
		logic [1:0]  cmd;
		logic [63:0] pair;
	} list_op_t;

	// one result item as the block should deliver it
	typedef struct {
		logic               has_element;
		logic signed [31:0] row;
		logic signed [31:0] col;
		logic               status;
		logic               last;
	} list_result_t;

	logic clk;
	logic arst_n;
	logic merge_mode_we;
	logic merge_mode_wdata;

	spmd_in_if  in_ch();
	spmd_out_if out_ch();

	sorted_pair_merge_difference dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_ch            (in_ch),
		.out_ch           (out_ch),
		.merge_mode_we    (merge_mode_we),
		.merge_mode_wdata (merge_mode_wdata)
	);

	// predicted block state: stored list, its fill level, the read cursor and the mode
	logic [63:0] held_pairs [spmd_pkg::ListDepth];
	int          held_count;
	int          held_cursor;
	logic        list_mode;

	list_op_t     ops_pending [$];  // items not yet offered to the block
	list_result_t results_due [$];  // results the block still owes, oldest first

	// blocking mirror of in_ch.valid, so the sequencer never misses an item in flight
	bit offering;

	int send_idle_pct;
	int stall_pct;
	int phase_items;
	int items_taken;
	int results_checked;
	int appends_refused;
	int pairs_emitted;
	int errors;

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// lexicographic (row, col) order on signed halves: flip both sign bits, compare unsigned
	function automatic bit pair_below(logic [63:0] a, logic [63:0] b);
		return (a ^ spmd_pkg::OrderFlip) < (b ^ spmd_pkg::OrderFlip);
	endfunction

	function automatic void owe_result(bit has, logic [63:0] pair, bit refused);
		list_result_t r;
		r.has_element = has;
		r.row         = has ? pair[63:32] : 32'd0;
		r.col         = has ? pair[31:0] : 32'd0;
		r.status      = refused;
		r.last        = 1'b0;
		results_due.push_back(r);
		if (has)
			pairs_emitted++;
	endfunction

	// advance the predicted state by one accepted item and queue the results it causes
	function automatic void step_pair_list(logic [1:0] cmd, logic [63:0] pair);
		int owed_before;
		list_result_t tail;
		owed_before = results_due.size();
		case (cmd)
			spmd_pkg::CMD_CLEAR: begin
				held_count  = 0;
				held_cursor = 0;
				owe_result(0, '0, 0);
			end
			spmd_pkg::CMD_APPEND: begin
				if (held_count >= spmd_pkg::ListDepth) begin
					owe_result(0, '0, 1);
					appends_refused++;
				end else begin
					held_pairs[held_count] = pair;
					held_count++;
					owe_result(0, '0, 0);
				end
			end
			spmd_pkg::CMD_PAIR: begin
				if (list_mode == spmd_pkg::MODE_MERGE) begin
					// stored pairs strictly below go out first, a tie lets the streamed pair lead
					while (held_cursor < held_count && pair_below(held_pairs[held_cursor], pair)) begin
						owe_result(1, held_pairs[held_cursor], 0);
						held_cursor++;
					end
					owe_result(1, pair, 0);
				end else if (held_cursor < held_count && held_pairs[held_cursor] == pair) begin
					held_cursor++;
					owe_result(0, '0, 0);
				end else begin
					owe_result(1, pair, 0);
				end
			end
			default: begin
				if (list_mode == spmd_pkg::MODE_MERGE) begin
					while (held_cursor < held_count) begin
						owe_result(1, held_pairs[held_cursor], 0);
						held_cursor++;
					end
				end
				held_cursor = 0;
				if (results_due.size() == owed_before)
					owe_result(0, '0, 0);
			end
		endcase
		tail = results_due.pop_back();
		tail.last = 1'b1;
		results_due.push_back(tail);
	endfunction

	// driver: offers queued items, holding each until the block takes it
	always @(posedge clk) begin : drive_items
		list_op_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			offering = 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				// sampled values are the ones the block just took
				step_pair_list(in_ch.cmd, {in_ch.elem_row, in_ch.elem_col});
				items_taken++;
				offering = 1'b0;
			end
			if (!offering) begin
				if (ops_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = ops_pending.pop_front();
					in_ch.valid    <= 1'b1;
					in_ch.cmd      <= nxt.cmd;
					in_ch.elem_row <= nxt.pair[63:32];
					in_ch.elem_col <= nxt.pair[31:0];
					offering = 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted result against the oldest owed one, stalls at random
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_checked++;
				if (results_due.size() == 0) begin
					errors++;
					$error("result item with nothing owed: row %0d col %0d",
						out_ch.out_row, out_ch.out_col);
				end else begin
					want = results_due.pop_front();
					if (out_ch.has_element !== want.has_element) begin
						errors++;
						$error("has_element: expected %0d, got %0d",
							want.has_element, out_ch.has_element);
					end
					if (out_ch.out_row !== want.row) begin
						errors++;
						$error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
					end
					if (out_ch.out_col !== want.col) begin
						errors++;
						$error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
					end
					if (out_ch.status !== want.status) begin
						errors++;
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
					end
					if (out_ch.last !== want.last) begin
						errors++;
						$error("last: expected %0d, got %0d", want.last, out_ch.last);
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// coordinates: a third near zero for ties and order, some extremes, the rest full range
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0, 1, 2: return 32'(int'($urandom_range(6)) - 3);
			3, 4: begin
				case ($urandom_range(4))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return COORD_NEG1;
					3: return 32'd0;
					default: return 32'd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick_pair();
		return {pick_coord(), pick_coord()};
	endfunction

	// insertion sort in signed (row, col) order
	function automatic void sort_pairs(ref logic [63:0] q [$]);
		logic [63:0] p;
		int j;
		for (int i = 1; i < q.size(); i++) begin
			p = q[i];
			j = i - 1;
			while (j >= 0 && pair_below(p, q[j])) begin
				q[j + 1] = q[j];
				j--;
			end
			q[j + 1] = p;
		end
	endfunction

	task automatic queue_op(logic [1:0] cmd, logic [63:0] pair);
		list_op_t op;
		op.cmd  = cmd;
		op.pair = pair;
		ops_pending.push_back(op);
		phase_items++;
	endtask

	// one list session: mostly clear, sorted appends, a sorted stream and the end marker;
	// now and then an unsorted list, a stray item, a missing clear or a missing end marker
	task automatic queue_session(bit overfill);
		logic [63:0] stored [$];
		logic [63:0] streamed [$];
		int n_store;
		int n_stream;
		if (overfill || $urandom_range(9) < 8)
			queue_op(spmd_pkg::CMD_CLEAR, pick_pair());
		if (overfill)
			n_store = spmd_pkg::ListDepth + 3;
		else if ($urandom_range(11) == 0)
			n_store = $urandom_range(24, spmd_pkg::ListDepth + 4);
		else
			n_store = $urandom_range(0, 6);
		repeat (n_store)
			stored.push_back(pick_pair());
		if ($urandom_range(9) != 0)
			sort_pairs(stored);
		foreach (stored[i])
			queue_op(spmd_pkg::CMD_APPEND, stored[i]);
		// half the streamed pairs repeat stored ones, for ties and removals
		n_stream = $urandom_range(0, 7);
		repeat (n_stream) begin
			if (stored.size() != 0 && $urandom_range(1) == 1)
				streamed.push_back(stored[$urandom_range(stored.size() - 1)]);
			else
				streamed.push_back(pick_pair());
		end
		if ($urandom_range(9) != 0)
			sort_pairs(streamed);
		foreach (streamed[i]) begin
			if ($urandom_range(19) == 0)
				queue_op(2'($urandom_range(3)), pick_pair());
			queue_op(spmd_pkg::CMD_PAIR, streamed[i]);
		end
		if ($urandom_range(9) != 0)
			queue_op(spmd_pkg::CMD_END, pick_pair());
	endtask

	// wait until every item is taken and every owed result has come back
	task automatic drain();
		while (ops_pending.size() != 0 || offering || results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mode writes only happen with the block idle
	task automatic write_mode(logic mode);
		drain();
		merge_mode_we    <= 1'b1;
		merge_mode_wdata <= mode;
		@(posedge clk);
		merge_mode_we <= 1'b0;
		list_mode = mode;
	endtask

	initial begin : sequencer
		int ph;
		// every block input known from time zero
		in_ch.valid      = 1'b0;
		in_ch.cmd        = spmd_pkg::CMD_CLEAR;
		in_ch.elem_row   = '0;
		in_ch.elem_col   = '0;
		out_ch.ready     = 1'b0;
		merge_mode_we    = 1'b0;
		merge_mode_wdata = spmd_pkg::MODE_MERGE;
		arst_n           = 1'b0;
		offering         = 1'b0;
		held_count       = 0;
		held_cursor      = 0;
		list_mode        = spmd_pkg::MODE_MERGE;
		send_idle_pct    = 0;
		stall_pct        = 0;
		phase_items      = 0;
		items_taken      = 0;
		results_checked  = 0;
		appends_refused  = 0;
		pairs_emitted    = 0;
		errors           = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed merge: extremes, a tie, releases before a pair, end marker twice
		write_mode(spmd_pkg::MODE_MERGE);
		queue_op(spmd_pkg::CMD_CLEAR, '0);
		queue_op(spmd_pkg::CMD_APPEND, {COORD_MIN, COORD_MIN});
		queue_op(spmd_pkg::CMD_APPEND, {COORD_NEG1, 32'd5});
		queue_op(spmd_pkg::CMD_APPEND, {32'd0, 32'd0});
		queue_op(spmd_pkg::CMD_APPEND, {COORD_MAX, COORD_MAX});
		queue_op(spmd_pkg::CMD_PAIR, {COORD_NEG1, 32'd5});
		queue_op(spmd_pkg::CMD_PAIR, {32'd0, COORD_NEG1});
		queue_op(spmd_pkg::CMD_PAIR, {COORD_MAX, COORD_MIN});
		queue_op(spmd_pkg::CMD_END, {COORD_MAX, COORD_MAX});
		queue_op(spmd_pkg::CMD_END, '0);

		// directed difference: drops, a near miss, cursor reset, an append mid-stream;
		// no end marker at the close, so the next phase switches mode with the cursor in place
		write_mode(spmd_pkg::MODE_DIFF);
		queue_op(spmd_pkg::CMD_CLEAR, {COORD_MAX, COORD_MAX});
		queue_op(spmd_pkg::CMD_APPEND, {32'hffff_fffb, 32'hffff_fffb});
		queue_op(spmd_pkg::CMD_APPEND, {32'd7, COORD_MIN});
		queue_op(spmd_pkg::CMD_APPEND, {COORD_MAX, COORD_NEG1});
		queue_op(spmd_pkg::CMD_PAIR, {32'hffff_fffb, 32'hffff_fffb});
		queue_op(spmd_pkg::CMD_PAIR, {32'd7, COORD_MAX});
		queue_op(spmd_pkg::CMD_PAIR, {32'd7, COORD_MIN});
		queue_op(spmd_pkg::CMD_END, '0);
		queue_op(spmd_pkg::CMD_PAIR, {32'hffff_fffb, 32'hffff_fffb});
		queue_op(spmd_pkg::CMD_APPEND, {COORD_MIN, COORD_MAX});
		queue_op(spmd_pkg::CMD_PAIR, {COORD_MAX, COORD_NEG1});

		// random phases: both modes under each idle pattern
		for (ph = 0; ph < 8; ph++) begin
			write_mode((ph % 2 == 1) ? spmd_pkg::MODE_DIFF : spmd_pkg::MODE_MERGE);
			case (ph / 2)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 87;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 87;
				end
				default: begin
					send_idle_pct = 36;
					stall_pct     = 36;
				end
			endcase
			phase_items = 0;
			// first random phase pushes the list past capacity
			if (ph == 0)
				queue_session(1);
			while (phase_items < 46)
				queue_session(0);
		end

		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d input items in both modes under four idle patterns,", items_taken);
		$display("%0d result items checked, %0d pairs emitted, %0d appends refused as full",
			results_checked, pairs_emitted, appends_refused);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
